>>> design/apsi_pkg.sv
// Package for the articulated-part slew integrator: types, constants, codes.
`default_nettype none
package apsi_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam logic [15:0] ZERO_BUTTON_RESET = 16'd5;
  localparam logic signed [31:0] PI_Q16 = 32'sd205887;
  localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_AXIS    = 3'd1,
    ACT_BUTTON  = 3'd2,
    ACT_CHANNEL = 3'd3,
    ACT_ENTITY  = 3'd4,
    ACT_LOAD    = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        delta_time;
    logic [2:0]         slot;
    logic signed [15:0] axis_value;
    logic [15:0]        button_id;
    logic               flag_on;
    logic               entity_dead;
    logic signed [31:0] slew_rate;
    logic signed [31:0] centre_value;
    logic signed [31:0] low_limit;
    logic signed [31:0] high_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_slot;
    logic signed [31:0] new_position;
    logic signed [31:0] rate_now;
    logic               last;
  } out_item_t;

  // Sequencer states for the tick walk
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL1,
    ST_MUL2,
    ST_WRITE
  } state_t;

  // Operand selection for the shared multiplier
  typedef struct packed {
    logic               sel_stick;
  } mul_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647) return 32'sh7fffffff;
    if (x < -34'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

>>> design/apsi_mul.sv
// Shared signed 32x17 multiplier with registered product.
`default_nettype none
module apsi_mul (
  input  wire                 clk,
  input  wire apsi_pkg::mul_ctl_t ctl,
  input  wire signed [31:0]   a,
  input  wire signed [15:0]   stick,
  input  wire [15:0]          dt,
  output logic signed [48:0]  prod
);
  import apsi_pkg::*;
  logic signed [16:0] b;

  // second operand: signed stick or unsigned dt
  assign b = ctl.sel_stick ? {stick[15], stick} : {1'b0, dt};

  // both operands widened to the full product width before the multiply
  always_ff @(posedge clk) begin
    prod <= 49'(a) * 49'(b);
  end
endmodule
`default_nettype wire

>>> design/articulated_part_slew_integrator_unit.sv
// Top level of the articulated-part slew integrator.
//  channel | signals                    | handshake
//  in      | start, busy, in_item       | transfer when start && !busy
//  out     | result_valid, result       | one-cycle strobe, no stall
//  cfg     | cfg_valid, cfg_ready, cfg_data | transfer when valid && ready
// Non-tick items never make the unit busy. A running tick walks each
// enabled slot through fetch, two passes through the shared multiplier and
// write. Only the multiplier is shared.
// Synchronous reset clears all slot tables, the status flags and the channel count at once.
// Results cannot be stalled; busy is high while a tick walks the enabled slots.
`default_nettype none
module articulated_part_slew_integrator_unit #(
  parameter int NUM_SLOTS = apsi_pkg::NUM_SLOTS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire apsi_pkg::in_item_t  in_item,
  output logic                 result_valid,
  output apsi_pkg::out_item_t  result,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [15:0]           cfg_data
);
  import apsi_pkg::*;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic signed [31:0] position [NUM_SLOTS];
  logic signed [31:0] rate_tab [NUM_SLOTS];
  logic signed [31:0] centre [NUM_SLOTS];
  logic signed [31:0] min_tab [NUM_SLOTS];
  logic signed [31:0] max_tab [NUM_SLOTS];
  logic signed [15:0] stick [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] limited, enabled;
  logic homing, dead, present;
  logic [7:0] channels;
  logic [15:0] zero_button;

  state_t state, state_next;
  logic [SW-1:0] idx;
  logic [15:0] dt;
  logic all_arrived;
  logic signed [31:0] cur_rate, val;
  logic signed [48:0] prod;
  mul_ctl_t mctl;
  logic signed [31:0] mul_a;

  logic run_tick, accept;
  logic [6:0] sidx;
  logic slot_ok;
  logic more;
  logic [SW-1:0] nxt;
  logic [SW-1:0] wslot;

  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign sidx = 7'(in_item.slot);
  assign wslot = SW'(in_item.slot);
  assign slot_ok = sidx < 7'(NUM_SLOTS);
  assign run_tick = accept && in_item.action == ACT_TICK && !dead && present
                    && channels != 8'd0;

  // search next enabled slot at or after a start point (combinational scan)
  function automatic logic [SW:0] find_en(input logic [NUM_SLOTS-1:0] en,
                                          input int from);
    logic [SW:0] r;
    r = {1'b1, SW'(0)};
    for (int k = NUM_SLOTS - 1; k >= 0; k--)
      if (k >= from && en[k]) r = {1'b0, SW'(k)};
    return r;
  endfunction

  logic [SW:0] first_en, next_en;
  assign first_en = find_en(enabled, 0);
  assign next_en = find_en(enabled, int'(idx) + 1);
  assign more = !next_en[SW];
  assign nxt = next_en[SW-1:0];

  // homing side selection for the current slot
  logic signed [32:0] wrapped;
  logic toward_up;
  always_comb begin
    wrapped = 33'(position[idx]);
    if (position[idx] < -PI_Q16) wrapped = 33'(position[idx]) + 33'(TWO_PI_Q16);
    else if (position[idx] > PI_Q16) wrapped = 33'(position[idx]) - 33'(TWO_PI_Q16);
    toward_up = wrapped < 33'(centre[idx]);
  end

  // multiplier operands
  always_comb begin
    mctl.sel_stick = (state == ST_FETCH) && !homing;
    mul_a = (state == ST_FETCH) ? rate_tab[idx] : cur_rate;
  end

  apsi_mul u_mul (
    .clk(clk), .ctl(mctl), .a(mul_a), .stick(stick[idx]), .dt(dt), .prod(prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (run_tick && !first_en[SW]) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_WRITE;
      ST_WRITE: state_next = more ? ST_FETCH : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // final value for the slot
  logic signed [33:0] sum;
  logic signed [31:0] fin_val, fin_rate;
  logic arrive;
  always_comb begin
    sum = 34'(val) + 34'($signed(prod[47:16]));
    fin_rate = cur_rate;
    arrive = 1'b0;
    if (homing) begin
      if (toward_up ? (sum >= 34'(centre[idx])) : (sum <= 34'(centre[idx]))) begin
        sum = 34'(centre[idx]);
        fin_rate = '0;
        arrive = 1'b1;
      end
    end else if (limited[idx]) begin
      if (sum > 34'(max_tab[idx])) begin
        sum = 34'(max_tab[idx]); fin_rate = '0;
      end else if (sum < 34'(min_tab[idx])) begin
        sum = 34'(min_tab[idx]); fin_rate = '0;
      end
    end else begin
      if (sum > 34'(TWO_PI_Q16)) sum = sum - 34'(TWO_PI_Q16);
      else if (sum < -34'(TWO_PI_Q16)) sum = sum + 34'(TWO_PI_Q16);
    end
    fin_val = sat32(sum);
  end

  // outputs
  always_comb begin
    result_valid = (state == ST_WRITE);
    result.out_slot = 3'(idx);
    result.new_position = fin_val;
    result.rate_now = fin_rate;
    result.last = !more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      enabled <= '0;
      limited <= '0;
      homing <= 1'b0;
      dead <= 1'b0;
      present <= 1'b0;
      channels <= '0;
      zero_button <= ZERO_BUTTON_RESET;
      idx <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        position[i] <= '0; rate_tab[i] <= '0; centre[i] <= '0;
        min_tab[i] <= '0; max_tab[i] <= '0; stick[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) zero_button <= cfg_data;
      if (accept) begin
        case (in_item.action)
          ACT_TICK: begin
            dt <= in_item.delta_time;
            idx <= first_en[SW-1:0];
            all_arrived <= 1'b1;
            if (run_tick && first_en[SW]) homing <= 1'b0;
          end
          ACT_AXIS: if (slot_ok && enabled[wslot]) begin
            stick[wslot] <= in_item.axis_value;
            homing <= 1'b0;
          end
          ACT_BUTTON: if (in_item.button_id == zero_button && in_item.flag_on)
            homing <= 1'b1;
          ACT_CHANNEL: begin
            if (in_item.flag_on) begin
              if (channels != 8'hff) channels <= channels + 8'd1;
            end else if (channels != 8'd0) channels <= channels - 8'd1;
          end
          ACT_ENTITY: begin
            present <= in_item.flag_on;
            dead <= in_item.entity_dead;
          end
          ACT_LOAD: if (slot_ok) begin
            rate_tab[wslot] <= in_item.slew_rate;
            centre[wslot] <= in_item.centre_value;
            min_tab[wslot] <= in_item.low_limit;
            max_tab[wslot] <= in_item.high_limit;
            limited[wslot] <= in_item.low_limit < in_item.high_limit;
            enabled[wslot] <= 1'b1;
          end
          default: ;
        endcase
      end
      case (state)
        ST_FETCH: begin
          val <= homing ? wrapped[31:0] : position[idx];
          if (homing) cur_rate <= toward_up ? rate_tab[idx]
                                  : sat32(-34'(rate_tab[idx]));
        end
        ST_MUL1: if (!homing) cur_rate <= sat32(34'(prod >>> 15));
        ST_WRITE: begin
          position[idx] <= fin_val;
          if (homing && !arrive) all_arrived <= 1'b0;
          if (!more && homing && (all_arrived && (arrive || !homing)))
            homing <= 1'b0;
          idx <= nxt;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !result_valid) else $error("result outside walk");
  a_busy_walk: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result while not busy");
  a_en_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> enabled[idx]) else $error("result for disabled slot");
`endif
endmodule
`default_nettype wire
